[hw/rtl/ata_pst_pkg.sv]
package ata_pst_pkg;

  // Field widths of the two channels.
  localparam int OPCODE_W = 3;
  localparam int LBA_W    = 28;
  localparam int SCOUNT_W = 16;
  localparam int STATUS_W = 8;
  localparam int WORD_W   = 16;
  localparam int KIND_W   = 3;
  localparam int OFFSET_W = 3;

  // Internal state widths.
  localparam int TICK_W           = 12;
  localparam int WORDS_W          = 17;
  localparam int WORDS_PER_SECTOR = 256;

  // Defaults for the top-level parameters.
  localparam int CHUNK_SECTORS_DEF = 256;
  localparam int COUNT_BITS_DEF    = 16;

  // Result list: one optional leading result and up to seven from a chunk issue.
  localparam int MAX_RESULTS  = 8;
  localparam int TAIL_RESULTS = 7;
  localparam int RCOUNT_W     = 4;
  localparam int RIDX_W       = 3;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 28;
  localparam logic [TICK_W-1:0] POLL_TICK_LIMIT_RST = 12'd3000;
  localparam logic [LBA_W-1:0]  LBA_LIMIT_RST       = 28'd163839;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_POLL_TICK_LIMIT = 1'd0,
    CFG_LBA_LIMIT       = 1'd1
  } cfg_reg_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_START  = 3'd0,
    OP_INTR   = 3'd1,
    OP_STATUS = 3'd2,
    OP_DATA   = 3'd3,
    OP_TICK   = 3'd4
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REG_WR    = 3'd0,
    KIND_REG_RD    = 3'd1,
    KIND_HOST_DATA = 3'd2,
    KIND_DONE      = 3'd3,
    KIND_TIMEOUT   = 3'd4,
    KIND_ERROR     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_WAIT_RINTR = 3'd1,
    PH_POLL       = 3'd2,
    PH_WAIT_TICK  = 3'd3,
    PH_READ_DATA  = 3'd4,
    PH_WRITE_DATA = 3'd5,
    PH_WAIT_WINTR = 3'd6
  } phase_t;

  // Task-file register offsets.
  localparam logic [OFFSET_W-1:0] OFF_NONE       = 3'd0;
  localparam logic [OFFSET_W-1:0] OFF_DATA       = 3'd0;
  localparam logic [OFFSET_W-1:0] OFF_SECCOUNT   = 3'd2;
  localparam logic [OFFSET_W-1:0] OFF_LBA_LO     = 3'd3;
  localparam logic [OFFSET_W-1:0] OFF_LBA_MID    = 3'd4;
  localparam logic [OFFSET_W-1:0] OFF_LBA_HI     = 3'd5;
  localparam logic [OFFSET_W-1:0] OFF_DEVICE     = 3'd6;
  localparam logic [OFFSET_W-1:0] OFF_CMD_STATUS = 3'd7;

  // Device register bits, status bits and commands.
  localparam logic [7:0] DEV_FIXED = 8'ha0;
  localparam logic [7:0] DEV_LBA   = 8'h40;
  localparam logic [7:0] DEV_SLAVE = 8'h10;
  localparam logic [7:0] ST_BSY    = 8'h80;
  localparam logic [7:0] ST_DRQ    = 8'h08;
  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;

  typedef struct packed {
    kind_t               kind;
    logic [OFFSET_W-1:0] reg_offset;
    logic [WORD_W-1:0]   value;
  } result_t;

  // All results caused by one input item, in order.
  typedef struct packed {
    logic [RCOUNT_W-1:0]            count;
    result_t [MAX_RESULTS-1:0]      items;
  } batch_t;

  function automatic result_t mk_result(input kind_t k, input logic [OFFSET_W-1:0] off,
                                        input logic [WORD_W-1:0] val);
    result_t r;
    r.kind       = k;
    r.reg_offset = off;
    r.value      = val;
    return r;
  endfunction

endpackage

[hw/rtl/ata_pst_in_if.sv]
interface ata_pst_in_if;
  import ata_pst_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [LBA_W-1:0]    start_lba;
  logic [SCOUNT_W-1:0] sector_count;
  logic                is_write;
  logic                drive_sel;
  logic [STATUS_W-1:0] status_byte;
  logic [WORD_W-1:0]   data_word;

  modport source (
    output valid, opcode, start_lba, sector_count, is_write, drive_sel, status_byte,
           data_word,
    input  ready
  );

  modport sink (
    input  valid, opcode, start_lba, sector_count, is_write, drive_sel, status_byte,
           data_word,
    output ready
  );

endinterface

[hw/rtl/ata_pst_out_if.sv]
interface ata_pst_out_if;
  import ata_pst_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [OFFSET_W-1:0] reg_offset;
  logic [WORD_W-1:0]   value;
  logic                last;

  modport source (
    output valid, kind, reg_offset, value, last,
    input  ready
  );

  modport sink (
    input  valid, kind, reg_offset, value, last,
    output ready
  );

endinterface

[hw/rtl/ata_pio_sector_transfer.sv]
// Channel  Dir  Beat contents
// req      in   opcode, start_lba, sector_count, is_write, drive_sel, status_byte, data_word
// rsp      out  kind, reg_offset, value, last
// cfg      in   cfg_write, cfg_index, cfg_data (write only)
//
// An accepted beat is registered, then its state update and all of its results (up to
// eight) are formed together and loaded into the registered result list. While rsp is
// ready the list sends one beat per cycle; an item with several results holds it until
// its final beat leaves, and items with one or no result sustain one per cycle.
// rst is synchronous and returns the sequencer to idle with the register defaults.
// A stall on rsp holds the list; req keeps accepting until the input register is full.
module ata_pio_sector_transfer #(
  parameter int CHUNK_SECTORS = ata_pst_pkg::CHUNK_SECTORS_DEF,
  parameter int COUNT_BITS    = ata_pst_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ata_pst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ata_pst_pkg::CFG_DATA_W-1:0]  cfg_data,
  ata_pst_in_if.sink                          req,
  ata_pst_out_if.source                       rsp
);
  import ata_pst_pkg::*;

  batch_t batch;
  logic   load;
  logic   free;

  ata_pst_step #(
    .CHUNK_SECTORS (CHUNK_SECTORS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .free      (free),
    .load      (load),
    .batch     (batch)
  );

  ata_pst_out_seq u_out_seq (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .batch (batch),
    .free  (free),
    .rsp   (rsp)
  );

endmodule

[hw/rtl/ata_pst_step.sv]
module ata_pst_step #(
  parameter int CHUNK_SECTORS = ata_pst_pkg::CHUNK_SECTORS_DEF,
  parameter int COUNT_BITS    = ata_pst_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ata_pst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ata_pst_pkg::CFG_DATA_W-1:0]  cfg_data,
  ata_pst_in_if.sink                          req,
  input  logic                                free,
  output logic                                load,
  output ata_pst_pkg::batch_t                 batch
);
  import ata_pst_pkg::*;

  localparam int CNT_W = (COUNT_BITS < SCOUNT_W) ? COUNT_BITS : SCOUNT_W;
  localparam int CHK_W = $clog2(CHUNK_SECTORS + 1);

  // Configuration registers.
  logic [TICK_W-1:0] poll_tick_limit;
  logic [LBA_W-1:0]  lba_limit;

  // Input register.
  logic                ir_valid;
  logic [OPCODE_W-1:0] ir_opcode;
  logic [LBA_W-1:0]    ir_lba;
  logic [SCOUNT_W-1:0] ir_count;
  logic                ir_write;
  logic                ir_drive;
  logic [STATUS_W-1:0] ir_status;
  logic [WORD_W-1:0]   ir_word;

  // Sequencer state.
  phase_t             phase, phase_next;
  logic [LBA_W-1:0]   lba_cursor, lba_cursor_next;
  logic [CNT_W-1:0]   sectors_left, sectors_left_next;
  logic [WORDS_W-1:0] words_left, words_left_next;
  logic [TICK_W-1:0]  poll_ticks, poll_ticks_next;
  logic               expect_interrupt, expect_interrupt_next;
  logic               dir_write, dir_write_next;
  logic               drive_latched, drive_latched_next;

  opcode_t            op;
  logic [CNT_W-1:0]   cnt;
  logic [CHK_W-1:0]   chunk_cur;
  logic [CHK_W-1:0]   chunk_iss;
  logic [TICK_W-1:0]  ticks_inc;
  logic               timeout_hit;
  logic [WORDS_W-1:0] words_drq;
  logic [WORDS_W-1:0] words_dec;
  logic [CNT_W-1:0]   fin_sectors;
  logic [LBA_W-1:0]   fin_lba;
  logic               start_ok;
  logic               st_bsy;
  logic               st_drq;
  logic               tail_done;
  logic               tail_issue;
  logic               take;

  result_t                    prefix;
  logic                       prefix_v;
  result_t [TAIL_RESULTS-1:0] tail;
  logic [RCOUNT_W-1:0]        tail_n;

  function automatic logic [CHK_W-1:0] chunk_of(input logic [CNT_W-1:0] left);
    logic [CHK_W-1:0] c;
    if (32'(left) < CHUNK_SECTORS) c = CHK_W'(left);
    else c = CHK_W'(CHUNK_SECTORS);
    return c;
  endfunction

  function automatic logic [7:0] dev_bits(input logic slave);
    return DEV_FIXED | DEV_LBA | (slave ? DEV_SLAVE : 8'h00);
  endfunction

  assign op          = opcode_t'(ir_opcode);
  assign cnt         = CNT_W'(ir_count);
  assign chunk_cur   = chunk_of(sectors_left);
  assign chunk_iss   = chunk_of(sectors_left_next);
  assign ticks_inc   = poll_ticks + TICK_W'(1);
  assign timeout_hit = ticks_inc >= poll_tick_limit;
  assign words_drq   = WORDS_W'(WORDS_W'(chunk_cur) * WORDS_W'(WORDS_PER_SECTOR));
  assign words_dec   = words_left - WORDS_W'(1);
  assign fin_sectors = sectors_left - CNT_W'(chunk_cur);
  assign fin_lba     = lba_cursor + LBA_W'(chunk_cur);
  assign start_ok    = (phase == PH_IDLE) && (cnt != '0) && (ir_lba <= lba_limit);
  assign st_bsy      = (ir_status & ST_BSY) != 8'h00;
  assign st_drq      = (ir_status & ST_DRQ) != 8'h00;

  // Next state.
  always_comb begin
    logic do_finish;
    logic do_abort;
    phase_next            = phase;
    lba_cursor_next       = lba_cursor;
    sectors_left_next     = sectors_left;
    words_left_next       = words_left;
    poll_ticks_next       = poll_ticks;
    expect_interrupt_next = expect_interrupt;
    dir_write_next        = dir_write;
    drive_latched_next    = drive_latched;
    do_finish             = 1'b0;
    do_abort              = 1'b0;
    tail_done             = 1'b0;
    tail_issue            = 1'b0;

    unique case (op)
      OP_START: begin
        if (start_ok) begin
          dir_write_next     = ir_write;
          drive_latched_next = ir_drive;
          lba_cursor_next    = ir_lba;
          sectors_left_next  = cnt;
          words_left_next    = '0;
          tail_issue         = 1'b1;
        end
      end
      OP_INTR: begin
        if (expect_interrupt) begin
          expect_interrupt_next = 1'b0;
          if (phase == PH_WAIT_RINTR) begin
            poll_ticks_next = '0;
            phase_next      = PH_POLL;
          end else if (phase == PH_WAIT_WINTR) begin
            do_finish = 1'b1;
          end
        end
      end
      OP_STATUS: begin
        if (phase == PH_POLL) begin
          if (st_bsy) begin
            poll_ticks_next = ticks_inc;
            if (timeout_hit) do_abort = 1'b1;
            else phase_next = PH_WAIT_TICK;
          end else if (st_drq) begin
            words_left_next = words_drq;
            phase_next      = dir_write ? PH_WRITE_DATA : PH_READ_DATA;
            if (words_drq == '0) begin
              if (dir_write && expect_interrupt) phase_next = PH_WAIT_WINTR;
              else do_finish = 1'b1;
            end
          end else begin
            do_abort = 1'b1;
          end
        end
      end
      OP_DATA: begin
        if (phase == PH_READ_DATA) begin
          words_left_next = words_dec;
          if (words_dec == '0) do_finish = 1'b1;
        end else if (phase == PH_WRITE_DATA) begin
          words_left_next = words_dec;
          if (words_dec == '0) begin
            if (expect_interrupt) phase_next = PH_WAIT_WINTR;
            else do_finish = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (phase == PH_WAIT_TICK) phase_next = PH_POLL;
      end
      default: ;
    endcase

    if (do_abort) begin
      phase_next            = PH_IDLE;
      expect_interrupt_next = 1'b0;
      sectors_left_next     = '0;
      words_left_next       = '0;
    end

    if (do_finish) begin
      sectors_left_next = fin_sectors;
      lba_cursor_next   = fin_lba;
      if (fin_sectors == '0) begin
        phase_next = PH_IDLE;
        tail_done  = 1'b1;
      end else begin
        tail_issue = 1'b1;
      end
    end

    if (tail_issue) begin
      expect_interrupt_next = 1'b1;
      if (dir_write_next) begin
        poll_ticks_next = '0;
        phase_next      = PH_POLL;
      end else begin
        phase_next = PH_WAIT_RINTR;
      end
    end
  end

  // Results.
  always_comb begin
    prefix_v = 1'b0;
    prefix   = mk_result(KIND_REG_WR, OFF_NONE, '0);
    tail     = '0;
    tail_n   = '0;

    unique case (op)
      OP_START: begin
        prefix_v = 1'b1;
        if (start_ok) prefix = mk_result(KIND_REG_WR, OFF_DEVICE,
                                         WORD_W'(dev_bits(ir_drive)));
        else prefix = mk_result(KIND_ERROR, OFF_NONE, '0);
      end
      OP_INTR: begin
        if (expect_interrupt) begin
          prefix_v = 1'b1;
          prefix   = mk_result(KIND_REG_RD, OFF_CMD_STATUS, '0);
        end
      end
      OP_STATUS: begin
        if (phase == PH_POLL) begin
          if (st_bsy) begin
            if (timeout_hit) begin
              prefix_v = 1'b1;
              prefix   = mk_result(KIND_TIMEOUT, OFF_NONE, '0);
            end
          end else if (!st_drq) begin
            prefix_v = 1'b1;
            prefix   = mk_result(KIND_ERROR, OFF_NONE, WORD_W'(ir_status));
          end
        end
      end
      OP_DATA: begin
        if (phase == PH_READ_DATA) begin
          prefix_v = 1'b1;
          prefix   = mk_result(KIND_HOST_DATA, OFF_NONE, ir_word);
        end else if (phase == PH_WRITE_DATA) begin
          prefix_v = 1'b1;
          prefix   = mk_result(KIND_REG_WR, OFF_DATA, ir_word);
        end
      end
      OP_TICK: begin
        if (phase == PH_WAIT_TICK) begin
          prefix_v = 1'b1;
          prefix   = mk_result(KIND_REG_RD, OFF_CMD_STATUS, '0);
        end
      end
      default: ;
    endcase

    // The chunk issue uses the cursor and count as they stand after this item.
    if (tail_issue) begin
      tail[0] = mk_result(KIND_REG_WR, OFF_SECCOUNT, WORD_W'(8'(chunk_iss)));
      tail[1] = mk_result(KIND_REG_WR, OFF_LBA_LO, WORD_W'(lba_cursor_next[7:0]));
      tail[2] = mk_result(KIND_REG_WR, OFF_LBA_MID, WORD_W'(lba_cursor_next[15:8]));
      tail[3] = mk_result(KIND_REG_WR, OFF_LBA_HI, WORD_W'(lba_cursor_next[23:16]));
      tail[4] = mk_result(KIND_REG_WR, OFF_DEVICE,
                          WORD_W'(dev_bits(drive_latched_next) |
                                  {4'h0, lba_cursor_next[27:24]}));
      tail[5] = mk_result(KIND_REG_WR, OFF_CMD_STATUS,
                          WORD_W'(dir_write_next ? CMD_WRITE : CMD_READ));
      if (dir_write_next) begin
        tail[6] = mk_result(KIND_REG_RD, OFF_CMD_STATUS, '0);
        tail_n  = RCOUNT_W'(7);
      end else begin
        tail_n = RCOUNT_W'(6);
      end
    end else if (tail_done) begin
      tail[0] = mk_result(KIND_DONE, OFF_NONE, '0);
      tail_n  = RCOUNT_W'(1);
    end
  end

  always_comb begin
    batch.count    = RCOUNT_W'(prefix_v) + tail_n;
    batch.items[0] = prefix_v ? prefix : tail[0];
    for (int i = 1; i < TAIL_RESULTS; i++) begin
      batch.items[i] = prefix_v ? tail[i-1] : tail[i];
    end
    batch.items[MAX_RESULTS-1] = prefix_v ? tail[TAIL_RESULTS-1] : '0;
  end

  // An item that causes no result only updates state, so it never waits.
  assign take      = ir_valid && ((batch.count == '0) || free);
  assign load      = take && (batch.count != '0);
  assign req.ready = !ir_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_tick_limit <= POLL_TICK_LIMIT_RST;
      lba_limit       <= LBA_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_POLL_TICK_LIMIT: poll_tick_limit <= cfg_data[TICK_W-1:0];
        CFG_LBA_LIMIT:       lba_limit       <= cfg_data[LBA_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (req.ready) begin
      ir_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      ir_opcode <= req.opcode;
      ir_lba    <= req.start_lba;
      ir_count  <= req.sector_count;
      ir_write  <= req.is_write;
      ir_drive  <= req.drive_sel;
      ir_status <= req.status_byte;
      ir_word   <= req.data_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      lba_cursor       <= '0;
      sectors_left     <= '0;
      words_left       <= '0;
      poll_ticks       <= '0;
      expect_interrupt <= 1'b0;
      dir_write        <= 1'b0;
      drive_latched    <= 1'b0;
    end else if (take) begin
      phase            <= phase_next;
      lba_cursor       <= lba_cursor_next;
      sectors_left     <= sectors_left_next;
      words_left       <= words_left_next;
      poll_ticks       <= poll_ticks_next;
      expect_interrupt <= expect_interrupt_next;
      dir_write        <= dir_write_next;
      drive_latched    <= drive_latched_next;
    end
  end

  // Every path back to idle consumes or clears the pending interrupt.
  a_idle_no_intr: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !expect_interrupt)
    else $error("idle with an interrupt still expected");

  a_busy_has_sectors: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> sectors_left != '0)
    else $error("transfer in progress with no sectors left");

endmodule

[hw/rtl/ata_pst_out_seq.sv]
module ata_pst_out_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  ata_pst_pkg::batch_t batch,
  output logic                free,
  ata_pst_out_if.source       rsp
);
  import ata_pst_pkg::*;

  result_t [MAX_RESULTS-1:0] items;
  logic [RIDX_W-1:0]         idx;
  logic [RIDX_W-1:0]         last_idx;
  logic                      list_valid;
  logic                      beat;
  logic                      final_beat;

  assign beat       = rsp.valid && rsp.ready;
  assign final_beat = beat && (idx == last_idx);
  // The list may be refilled in the same cycle that its final beat leaves.
  assign free       = !list_valid || final_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_valid <= 1'b0;
      idx        <= '0;
    end else if (load) begin
      list_valid <= 1'b1;
      idx        <= '0;
    end else if (final_beat) begin
      list_valid <= 1'b0;
    end else if (beat) begin
      idx <= idx + RIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items    <= batch.items;
      last_idx <= RIDX_W'(batch.count - RCOUNT_W'(1));
    end
  end

  assign rsp.valid      = list_valid;
  assign rsp.kind       = items[idx].kind;
  assign rsp.reg_offset = items[idx].reg_offset;
  assign rsp.value      = items[idx].value;
  assign rsp.last       = idx == last_idx;

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result list overwritten before it drained");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    list_valid |-> idx <= last_idx)
    else $error("result index ran past the end of the list");

  a_load_starts_list: assert property (@(posedge clk) disable iff (rst)
    load |=> rsp.valid && idx == '0)
    else $error("loaded list does not start at its first result");

endmodule
